// File: hdl/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// types and constants shared by the sorted matrix search block
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int MAX_ROWS_DEF   = 32;
    localparam int MAX_COLS_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;

    localparam logic [CFG_W-1:0] CNT_RESET = CFG_W'(32);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic signed [31:0] item_value;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_row;
        logic [IDX_W-1:0] found_col;
    } t_out_beat;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

// File: hdl/sorted_matrix_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_matrix_search
// staircase search over a row and column sorted matrix held in one memory
// ----------------------------------------------------------------------------
// load beat: written straight into the matrix memory
// search beat: one cell visited per cycle through the read-compare-readdress
//   loop on the memory port
// one item in flight at a time; the next beat is taken once the result is registered
// reset: control state cleared, both counts set to 32; the matrix memory is not cleared
// ----------------------------------------------------------------------------
module sorted_matrix_search
    import sms_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(MAX_COLS);
        return base + ADDR_W'(col);
    endfunction

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [CFG_W-1:0]             r_row_count;
    logic [CFG_W-1:0]             r_col_count;
    logic [RCNT_W-1:0]            r_row, n_row;
    logic [CCNT_W-1:0]            r_col, n_col;
    logic [RCNT_W-1:0]            r_rows;
    logic                         r_empty;
    logic signed [DATA_WIDTH-1:0] r_key;
    logic                         r_out_valid;
    t_out_beat                    r_out;

    logic [RCNT_W-1:0]            w_rows_sat;
    logic [CCNT_W-1:0]            w_cols_sat;
    logic signed [63:0]           w_ext;
    logic signed [DATA_WIDTH-1:0] w_word;
    logic                         w_accept;
    logic                         w_load_we;
    logic                         w_start;
    logic                         w_lt;
    logic                         w_eq;
    logic                         w_done;
    logic                         w_out_free;
    logic                         w_finish;
    logic [CCNT_W-1:0]            w_col_m1;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic [ADDR_W-1:0]            w_wr_addr;
    t_out_beat                    w_result;

    assign w_rows_sat = (32'(r_row_count) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                      : RCNT_W'(r_row_count);
    assign w_cols_sat = (32'(r_col_count) > MAX_COLS) ? CCNT_W'(MAX_COLS)
                                                      : CCNT_W'(r_col_count);
    assign w_ext      = 64'($signed(i_in.item_value));
    assign w_word     = w_ext[DATA_WIDTH-1:0];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && (i_in.mode == MODE_SEARCH);
    assign w_load_we  = w_accept && (i_in.mode == MODE_LOAD)
                        && (32'(i_in.row_index) < MAX_ROWS)
                        && (32'(i_in.col_index) < MAX_COLS);
    assign w_wr_addr  = addr_of(ROW_W'(i_in.row_index), COL_W'(i_in.col_index));

    assign w_lt       = r_rd_data < r_key;
    assign w_eq       = r_rd_data == r_key;
    assign w_done     = r_empty || w_eq
                        || (w_lt && (RCNT_W'(r_row + 1'b1) == r_rows))
                        || (!w_lt && (r_col == CCNT_W'(1)));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == ST_WALK) && w_done && w_out_free;
    assign w_col_m1   = r_col - 1'b1;

    assign w_result.found     = !r_empty && w_eq;
    assign w_result.found_row = w_result.found ? IDX_W'(r_row) : '0;
    assign w_result.found_col = w_result.found ? IDX_W'(w_col_m1) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and walk position
    always_comb begin
        o_in_ready = 1'b0;
        n_row      = r_row;
        n_col      = r_col;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_row      = '0;
                n_col      = w_cols_sat;
            end
            ST_WALK: begin
                if (!w_done) begin
                    if (w_lt) begin
                        n_row = RCNT_W'(r_row + 1'b1);
                    end else begin
                        n_col = w_col_m1;
                    end
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_rd_addr = addr_of(ROW_W'(n_row), COL_W'(n_col - 1'b1));

    // matrix memory
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_mem[w_wr_addr] <= w_word;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_count <= CNT_RESET;
            r_col_count <= CNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        if (w_start) begin
            r_rows  <= w_rows_sat;
            r_empty <= (w_rows_sat == '0) || (w_cols_sat == '0);
            r_key   <= w_word;
        end
        if (w_finish) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !r_empty) |-> (r_row < r_rows && r_col != '0))
        else $error("walk position left the matrix");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input taken during a walk");

    a_finish_posts_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished walk did not post a result");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && w_done && !w_out_free) |=> (r_state == ST_WALK))
        else $error("walk ended while the output was still full");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sorted_matrix_search: loads sorted and scrambled
// matrices at many row and column counts, searches hit and miss keys, and
// checks every result beat against a staircase walk over a local matrix copy
// ----------------------------------------------------------------------------
module testbench;
    import sms_pkg::*;

    localparam int GRID          = 32;
    localparam int SETTLE_CYCLES = 70;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 950;
    localparam int SPECIAL_COUNT = 9;

    localparam longint VAL_LO = -(64'sd1 <<< 31);
    localparam longint VAL_HI = (64'sd1 <<< 31) - 1;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_beat             in_beat  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_beat            out_beat;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    t_in_beat           pend_beats[$];
    t_out_beat          want_results[$];
    logic signed [31:0] matrix_copy[GRID][GRID];
    longint             grid_plan[GRID][GRID];
    logic [CFG_W-1:0]   rows_reg = CNT_RESET;
    logic [CFG_W-1:0]   cols_reg = CNT_RESET;

    int errors      = 0;
    int items_sent  = 0;
    int stall_count = 0;
    int hold_left   = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    sorted_matrix_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_beat staircase_walk(logic signed [31:0] key);
        t_out_beat res;
        int nr;
        int nc;
        int r;
        int c;
        res = '0;
        nr = (rows_reg > GRID) ? GRID : int'(rows_reg);
        nc = (cols_reg > GRID) ? GRID : int'(cols_reg);
        if (nr == 0 || nc == 0) begin
            return res;
        end
        r = 0;
        c = nc - 1;
        while (r < nr && c >= 0) begin
            if (matrix_copy[r][c] == key) begin
                res.found     = 1'b1;
                res.found_row = IDX_W'(r);
                res.found_col = IDX_W'(c);
                return res;
            end
            if (matrix_copy[r][c] < key) begin
                r++;
            end else begin
                c--;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
        errors++;
    endtask

    // driver: feeds pending beats, updates the matrix copy on each accepted load beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (in_beat.mode == MODE_LOAD) begin
                    matrix_copy[in_beat.row_index][in_beat.col_index] = in_beat.item_value;
                end else begin
                    want_results.push_back(staircase_walk(in_beat.item_value));
                end
            end
            if (!in_valid || in_ready) begin
                if (pend_beats.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
                    in_valid <= 1'b1;
                    in_beat  <= pend_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result beats, drives ready with random and long holds
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (want_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 0, 1);
                end else begin
                    want = want_results.pop_front();
                    if (out_beat.found !== want.found) begin
                        report_mismatch("found", want.found, out_beat.found);
                    end
                    if (out_beat.found_row !== want.found_row) begin
                        report_mismatch("found_row", want.found_row, out_beat.found_row);
                    end
                    if (out_beat.found_col !== want.found_col) begin
                        report_mismatch("found_col", want.found_col, out_beat.found_col);
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROW_COUNT) begin
            rows_reg = val;
        end else begin
            cols_reg = val;
        end
    endtask

    task automatic push_item(logic mode, int r, int c, logic signed [31:0] v);
        t_in_beat b;
        b.mode       = mode;
        b.row_index  = IDX_W'(r);
        b.col_index  = IDX_W'(c);
        b.item_value = v;
        pend_beats.push_back(b);
        items_sent++;
    endtask

    task automatic push_search(logic signed [31:0] key);
        push_item(MODE_SEARCH, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1), key);
    endtask

    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pend_beats.size() != 0 || in_valid || want_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic plan_grid(int nr, int nc, bit scramble);
        longint gap;
        longint lo;
        longint v;
        gap = (64'sd1 <<< 33) / (nr + nc + 1);
        if ($urandom_range(0, 3) == 0) begin
            gap = 4;
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                lo = VAL_LO;
                if (r > 0 && grid_plan[r-1][c] > lo) begin
                    lo = grid_plan[r-1][c];
                end
                if (c > 0 && grid_plan[r][c-1] > lo) begin
                    lo = grid_plan[r][c-1];
                end
                v = lo + longint'($urandom_range(0, 32'(gap - 1)));
                grid_plan[r][c] = (v > VAL_HI) ? VAL_HI : v;
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            grid_plan[0][0]       = VAL_LO;
            grid_plan[nr-1][nc-1] = VAL_HI;
        end
        if (scramble) begin
            for (int k = 0; k <= nr * nc / 4; k++) begin
                grid_plan[$urandom_range(0, nr - 1)][$urandom_range(0, nc - 1)] =
                    longint'($signed($urandom));
            end
        end
    endtask

    function automatic logic signed [31:0] pick_key(int nr, int nc);
        longint entry;
        int     sel;
        if (nr == 0 || nc == 0) begin
            return $urandom;
        end
        entry = grid_plan[$urandom_range(0, nr - 1)][$urandom_range(0, nc - 1)];
        sel   = $urandom_range(0, 9);
        if (sel < 5) begin
            return 32'(entry);
        end
        if (sel < 7) begin
            return ($urandom_range(0, 1) == 1) ? 32'(entry + 1) : 32'(entry - 1);
        end
        if (sel == 7) begin
            return ($urandom_range(0, 1) == 1) ? 32'(VAL_HI) : 32'(VAL_LO);
        end
        return $urandom;
    endfunction

    task automatic run_phase(int rows, int cols, int searches, bit scramble);
        int nr;
        int nc;
        int r2;
        int c2;
        write_reg(CFG_ROW_COUNT, CFG_W'(rows));
        write_reg(CFG_COL_COUNT, CFG_W'(cols));
        nr = (rows > GRID) ? GRID : rows;
        nc = (cols > GRID) ? GRID : cols;
        @(negedge i_clk);
        if (nr > 0 && nc > 0) begin
            plan_grid(nr, nc, scramble);
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                push_item(MODE_LOAD, r, c, 32'(grid_plan[r][c]));
                // stray load outside the used area
                if ((nr < GRID || nc < GRID) && $urandom_range(0, 9) == 0) begin
                    do begin
                        r2 = $urandom_range(0, GRID - 1);
                        c2 = $urandom_range(0, GRID - 1);
                    end while (r2 < nr && c2 < nc);
                    push_item(MODE_LOAD, r2, c2, $urandom);
                end
            end
        end
        for (int k = 0; k < searches; k++) begin
            push_search(pick_key(nr, nc));
        end
        settle();
    endtask

    initial begin
        int spec_rows[SPECIAL_COUNT] = '{32, 2, 63, 3, 33, 1, 0, 5, 1};
        int spec_cols[SPECIAL_COUNT] = '{2, 32, 3, 63, 1, 40, 5, 0, 1};
        int phase;
        int rows;
        int cols;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero row count, then zero column count
        write_reg(CFG_ROW_COUNT, CFG_W'(0));
        @(negedge i_clk);
        push_search(32'(VAL_LO));
        push_search(32'(VAL_HI));
        settle();
        write_reg(CFG_ROW_COUNT, CFG_W'(2));
        write_reg(CFG_COL_COUNT, CFG_W'(0));
        @(negedge i_clk);
        push_search(32'sd0);
        settle();

        // 2x2 with both extremes, hits and misses, then broken order
        write_reg(CFG_COL_COUNT, CFG_W'(2));
        @(negedge i_clk);
        push_item(MODE_LOAD, 0, 0, 32'(VAL_LO));
        push_item(MODE_LOAD, 0, 1, 32'sd0);
        push_item(MODE_LOAD, 1, 0, 32'sd5);
        push_item(MODE_LOAD, 1, 1, 32'(VAL_HI));
        push_item(MODE_LOAD, GRID - 1, GRID - 1, 32'sh5a5a_5a5a);
        push_search(32'(VAL_LO));
        push_search(32'(VAL_HI));
        push_search(32'sd3);
        push_search(-32'sd5);
        push_search(32'sd5);
        push_search(32'sd0);
        push_item(MODE_LOAD, 0, 0, 32'sd100);
        push_search(32'sd100);
        push_search(32'sd5);
        settle();

        items_sent = 0;
        phase      = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < SPECIAL_COUNT) begin
                rows = spec_rows[phase];
                cols = spec_cols[phase];
            end else begin
                rows = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                cols = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            end
            @(negedge i_clk);
            quiet = (phase == 11);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            run_phase(rows, cols, $urandom_range(12, 30), $urandom_range(0, 9) == 0);
            phase++;
        end

        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
